### sv/brpm_pkg.sv
// ----------------------------------------------------------------------------
// brpm_pkg
// Shared constants and the level scaling function of the RMS and peak meter.
// ----------------------------------------------------------------------------
package brpm_pkg;

   localparam int DEF_MAX_BLOCK   = 4096;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int LEVEL_W  = 15;
   localparam int FACTOR_W = 17;

   localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = 15'h7FFF;
   localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 17'h10000;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 17'h08000;

   // entries of the job queue between accumulator and block-end math
   localparam int QUEUE_DEPTH = 2;

   // move a magnitude in sample units to Q0.15, truncate, saturate
   function automatic logic [LEVEL_W-1:0] to_level(input logic [31:0] v, input int sb);
      logic [31:0] r;
      if (sb >= 16) begin
         r = v >> (sb - 16);
      end else begin
         r = v << (16 - sb);
      end
      return (r > 32'(LEVEL_MAX)) ? LEVEL_MAX : r[LEVEL_W-1:0];
   endfunction

endpackage

### sv/brpm_if.sv
// ----------------------------------------------------------------------------
// brpm_if
// Valid/ready channels of the meter: sample stream in, level results out.
// ----------------------------------------------------------------------------
interface brpm_req_if
   import brpm_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last;

   modport source (output valid, sample, last, input ready);
   modport sink   (input valid, sample, last, output ready);
endinterface

interface brpm_rsp_if
   import brpm_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] rms_level;
   logic [LEVEL_W-1:0] peak_level;

   modport source (output valid, rms_level, peak_level, input ready);
   modport sink   (input valid, rms_level, peak_level, output ready);
endinterface

### sv/brpm_front.sv
// ----------------------------------------------------------------------------
// brpm_front
// Sample pipeline: magnitude, square and level, then block accumulation.
// Hands each closed block to the job queue.
// ----------------------------------------------------------------------------
module brpm_front
   import brpm_pkg::*;
#(
   parameter int MAX_BLOCK   = DEF_MAX_BLOCK,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int SUM_W       = 43,
   parameter int CNT_W       = 13
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   input  logic                   in_last,
   output logic                   job_push,
   input  logic                   job_full,
   output logic [SUM_W-1:0]       job_sum,
   output logic [CNT_W-1:0]       job_cnt,
   output logic [LEVEL_W-1:0]     job_peak
);

   localparam int SB   = SAMPLE_BITS;
   localparam int SQ_W = 2 * SB - 1;

   logic [SB-1:0]      mag_in;
   logic               advance;
   logic               take;
   logic               counted;
   logic [2*SB-1:0]    sq_full;

   logic               v1_ff, v2_ff;
   logic               last1_ff, last2_ff;
   logic [SB-1:0]      mag1_ff;
   logic [SQ_W-1:0]    sq2_ff;
   logic [LEVEL_W-1:0] lvl2_ff;

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEVEL_W-1:0] peak_ff, peak_in;

   // two's complement magnitude, the most negative code maps to full scale
   assign mag_in  = in_sample[SB-1] ? (~in_sample + 1'b1) : in_sample;
   assign sq_full = {{SB{1'b0}}, mag1_ff} * {{SB{1'b0}}, mag1_ff};

   // stall only when a block end cannot be handed over
   assign advance  = !(v2_ff && last2_ff && job_full);
   assign in_ready = advance;
   assign take     = v2_ff && advance;
   assign job_push = take && last2_ff;

   assign counted = cnt_ff < CNT_W'(MAX_BLOCK);

   always_comb begin
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      peak_in = peak_ff;
      if (counted) begin
         sum_in = sum_ff + SUM_W'(sq2_ff);
         cnt_in = cnt_ff + 1'b1;
         if (lvl2_ff > peak_ff) begin
            peak_in = lvl2_ff;
         end
      end
   end

   assign job_sum  = sum_in;
   assign job_cnt  = cnt_in;
   assign job_peak = peak_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         sum_ff  <= '0;
         cnt_ff  <= '0;
         peak_ff <= '0;
      end else begin
         if (advance) begin
            v1_ff <= in_valid;
            v2_ff <= v1_ff;
         end
         if (take) begin
            if (last2_ff) begin
               sum_ff  <= '0;
               cnt_ff  <= '0;
               peak_ff <= '0;
            end else begin
               sum_ff  <= sum_in;
               cnt_ff  <= cnt_in;
               peak_ff <= peak_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag1_ff  <= mag_in;
         last1_ff <= in_last;
         sq2_ff   <= sq_full[SQ_W-1:0];
         lvl2_ff  <= to_level(32'(mag1_ff), SB);
         last2_ff <= last1_ff;
      end
   end

   a_clear_after_push: assert property (@(posedge clock) disable iff (reset)
      job_push |=> (cnt_ff == '0 && sum_ff == '0 && peak_ff == '0))
      else $error("accumulator not cleared after block end");

endmodule

### sv/brpm_queue.sv
// ----------------------------------------------------------------------------
// brpm_queue
// Short first-in first-out job queue between the accumulator and the math.
// ----------------------------------------------------------------------------
module brpm_queue
   import brpm_pkg::*;
#(
   parameter int WIDTH = 71,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] fill_ff;

   assign full     = fill_ff == CNT_W'(DEPTH);
   assign empty    = fill_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("job queue underflow");

endmodule

### sv/brpm_back.sv
// ----------------------------------------------------------------------------
// brpm_back
// Block-end math: mean by restoring division, integer square root two bits
// a step, smoothing multiply and update, then the result register.
// ----------------------------------------------------------------------------
module brpm_back
   import brpm_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int SUM_W       = 43,
   parameter int CNT_W       = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_empty,
   output logic                job_pop,
   input  logic [SUM_W-1:0]    job_sum,
   input  logic [CNT_W-1:0]    job_cnt,
   input  logic [LEVEL_W-1:0]  job_peak,
   input  logic [FACTOR_W-1:0] factor,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [LEVEL_W-1:0]  out_rms,
   output logic [LEVEL_W-1:0]  out_peak
);

   localparam int SB     = SAMPLE_BITS;
   localparam int Q_W    = 2 * SB - 1;
   localparam int R_W    = SB;
   localparam int RAD_W  = 2 * R_W;
   localparam int SREM_W = R_W + 2;
   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [2:0] {
      IDLE,
      DIVIDE,
      ROOT,
      SCALE,
      MULT,
      UPDATE
   } state_type;

   state_type state_ff;

   logic [SUM_W-1:0]    dvd_ff, dvd_in;
   logic [CNT_W-1:0]    div_ff;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W:0]      rem_sh, rem_diff;
   logic                div_ge;

   logic [RAD_W-1:0]    rad_ff;
   logic [SREM_W-1:0]   srem_ff, srem_sh, srem_trial, srem_diff;
   logic [R_W-1:0]      root_ff;
   logic                root_ge;

   logic [STEP_W-1:0]   step_ff;
   logic [LEVEL_W-1:0]  peak_ff;
   logic [LEVEL_W-1:0]  rms_ff;
   logic [FACTOR_W-1:0] f_ff;
   logic                up_now;
   logic                up_ff;
   logic [31:0]         prod_ff;
   logic [LEVEL_W-1:0]  diff_lvl;
   logic [LEVEL_W-1:0]  delta;
   logic [LEVEL_W-1:0]  smoothed_ff, smoothed_in;
   logic                out_free;

   logic                out_valid_ff;
   logic [LEVEL_W-1:0]  out_rms_ff, out_peak_ff;

   assign job_pop   = (state_ff == IDLE) && !job_empty;
   assign out_valid = out_valid_ff;
   assign out_rms   = out_rms_ff;
   assign out_peak  = out_peak_ff;
   assign out_free  = !out_valid_ff || out_ready;

   // one restoring division step, quotient bits enter at the bottom
   assign rem_sh   = {rem_ff, dvd_ff[SUM_W-1]};
   assign div_ge   = rem_sh >= {1'b0, div_ff};
   assign rem_diff = rem_sh - {1'b0, div_ff};
   assign rem_in   = div_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
   assign dvd_in   = {dvd_ff[SUM_W-2:0], div_ge};

   // one square root step on the next pair of radicand bits
   assign srem_sh    = {srem_ff[R_W-1:0], rad_ff[RAD_W-1 -: 2]};
   assign srem_trial = {root_ff, 2'b01};
   assign root_ge    = srem_sh >= srem_trial;
   assign srem_diff  = srem_sh - srem_trial;

   // delta never exceeds the distance, so no saturation is needed here
   assign up_now      = rms_ff >= smoothed_ff;
   assign diff_lvl    = up_now ? (rms_ff - smoothed_ff) : (smoothed_ff - rms_ff);
   assign delta       = prod_ff[16 +: LEVEL_W];
   assign smoothed_in = up_ff ? (smoothed_ff + delta) : (smoothed_ff - delta);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         out_valid_ff <= 1'b0;
         smoothed_ff  <= '0;
      end else begin
         if (out_valid_ff && out_ready && (state_ff != UPDATE)) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (!job_empty) begin
                  dvd_ff  <= job_sum;
                  div_ff  <= job_cnt;
                  peak_ff <= job_peak;
                  rem_ff  <= '0;
                  step_ff <= '0;
                  root_ff <= '0;
                  // an empty block skips straight to a zero root
                  state_ff <= (job_cnt == '0) ? SCALE : DIVIDE;
               end
            end
            DIVIDE: begin
               dvd_ff <= dvd_in;
               rem_ff <= rem_in;
               if (step_ff == STEP_W'(SUM_W - 1)) begin
                  rad_ff   <= {1'b0, dvd_in[Q_W-1:0]};
                  srem_ff  <= '0;
                  root_ff  <= '0;
                  step_ff  <= '0;
                  state_ff <= ROOT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ROOT: begin
               rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
               step_ff <= step_ff + 1'b1;
               if (root_ge) begin
                  srem_ff <= srem_diff;
                  root_ff <= {root_ff[R_W-2:0], 1'b1};
               end else begin
                  srem_ff <= srem_sh;
                  root_ff <= {root_ff[R_W-2:0], 1'b0};
               end
               if (step_ff == STEP_W'(R_W - 1)) begin
                  state_ff <= SCALE;
               end
            end
            SCALE: begin
               rms_ff   <= to_level(32'(root_ff), SB);
               f_ff     <= (factor > FACTOR_ONE) ? FACTOR_ONE : factor;
               state_ff <= MULT;
            end
            MULT: begin
               up_ff    <= up_now;
               state_ff <= UPDATE;
            end
            UPDATE: begin
               if (out_free) begin
                  smoothed_ff  <= smoothed_in;
                  out_rms_ff   <= smoothed_in;
                  out_peak_ff  <= peak_ff;
                  out_valid_ff <= 1'b1;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   // product of distance and weight, taken once the direction is known
   always_ff @(posedge clock) begin
      prod_ff <= 32'(diff_lvl) * 32'(f_ff);
   end

   a_smoothed_only_on_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != UPDATE) |=> $stable(smoothed_ff))
      else $error("smoothed level changed outside the update step");

endmodule

### sv/block_rms_peak_meter_core.sv
// ----------------------------------------------------------------------------
// block_rms_peak_meter_core
// Block RMS and peak audio level meter with smoothed RMS output.
//
//   channel   dir   handshake           payload
//   req_bus   in    valid/ready         sample (signed), last
//   rsp_bus   out   valid/ready         rms_level, peak_level (Q0.15)
//   csr       in    csr_we              csr_wdata: smoothing factor, Q1.16
//
// Samples are taken one per cycle while req ready is high; the front pipeline
// has three stages. Each block end runs through the serial divider and square
// root of the back part. Blocks closing faster than the back part works fill
// the two-entry job queue, then req ready drops.
// A waiting result does not stop the math on the next block until its update.
// Reset is synchronous; it clears all accumulators and the smoothed level.
// ----------------------------------------------------------------------------
module block_rms_peak_meter_core
   import brpm_pkg::*;
#(
   parameter int MAX_BLOCK   = DEF_MAX_BLOCK,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                clock,
   input  logic                reset,
   brpm_req_if.sink            req_bus,
   brpm_rsp_if.source          rsp_bus,
   input  logic                csr_we,
   input  logic [FACTOR_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W = 2 * SAMPLE_BITS - 2 + CNT_W;
   localparam int JOB_W = SUM_W + CNT_W + LEVEL_W;

   logic [FACTOR_W-1:0] factor_ff;

   logic               job_push, job_full, job_pop, job_empty;
   logic [SUM_W-1:0]   push_sum, pop_sum;
   logic [CNT_W-1:0]   push_cnt, pop_cnt;
   logic [LEVEL_W-1:0] push_peak, pop_peak;
   logic [JOB_W-1:0]   push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
      end else if (csr_we) begin
         factor_ff <= csr_wdata;
      end
   end

   brpm_front #(
      .MAX_BLOCK   (MAX_BLOCK),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W),
      .CNT_W       (CNT_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_sample (req_bus.sample),
      .in_last   (req_bus.last),
      .job_push  (job_push),
      .job_full  (job_full),
      .job_sum   (push_sum),
      .job_cnt   (push_cnt),
      .job_peak  (push_peak)
   );

   assign push_data = {push_sum, push_cnt, push_peak};
   assign {pop_sum, pop_cnt, pop_peak} = pop_data;

   brpm_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (pop_data),
      .empty     (job_empty)
   );

   brpm_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W),
      .CNT_W       (CNT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .job_sum   (pop_sum),
      .job_cnt   (pop_cnt),
      .job_peak  (pop_peak),
      .factor    (factor_ff),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_rms   (rsp_bus.rms_level),
      .out_peak  (rsp_bus.peak_level)
   );

endmodule
